// ===== src/mcsp_pkg.sv =====
package mcsp_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int FREQ_W       = 16;
  localparam int TB_W         = 10;
  localparam int DUTY_W       = 7;
  // 10 * share, share at most 100
  localparam int DIVIDEND_W   = 10;
  // freq_hz * timebase_ms
  localparam int DEN_W        = FREQ_W + TB_W;
  // a finite wait never exceeds 10 * 100
  localparam int WAIT_W       = 10;
  localparam int ELAPSED_W    = WAIT_W + 1;

  localparam logic [DUTY_W-1:0] DUTY_FULL  = DUTY_W'(100);
  localparam logic [WAIT_W-1:0] WAIT_LIMIT = WAIT_W'(1000);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  // Phase waits of one channel; inf marks a channel that never toggles
  typedef struct packed {
    logic              inf;
    logic [WAIT_W-1:0] hi;
    logic [WAIT_W-1:0] lo;
  } wait_res_t;

  // Commands from the sequencer to the channel bank
  typedef struct packed {
    logic            alloc;
    logic            stop;
    logic            commit;
    logic            step;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] scan;
    logic            lvl;
    wait_res_t       res;
  } bank_cmd_t;

  function automatic logic [DIVIDEND_W-1:0] dividend(input logic [DUTY_W-1:0] share);
    logic [DIVIDEND_W-1:0] s;
    s = DIVIDEND_W'(share);
    return (s << 3) + (s << 1);
  endfunction

endpackage

// ===== src/mcsp_wait_calc.sv =====
module mcsp_wait_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mcsp_pkg::FREQ_W-1:0]   freq_hz,
  input  logic [mcsp_pkg::TB_W-1:0]     timebase_ms,
  input  logic [mcsp_pkg::DUTY_W-1:0]   duty_pct,
  output logic                          done,
  output mcsp_pkg::wait_res_t           res
);

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_MUL  = 3'b010,
    W_DIV  = 3'b100
  } calc_state_t;

  localparam logic [3:0] MUL_LAST = 4'(mcsp_pkg::TB_W - 1);
  localparam logic [3:0] DIV_LAST = 4'(mcsp_pkg::DIVIDEND_W - 1);

  calc_state_t                         state;
  logic [3:0]                          cnt;
  logic [mcsp_pkg::DEN_W-1:0]          mcand;
  logic [mcsp_pkg::TB_W-1:0]           mplier;
  logic [mcsp_pkg::DEN_W-1:0]          den;
  logic [mcsp_pkg::DUTY_W-1:0]         duty_q;
  logic [mcsp_pkg::DIVIDEND_W-1:0]     num_sh;
  logic [mcsp_pkg::DIVIDEND_W-1:0]     rem;
  logic [mcsp_pkg::WAIT_W-1:0]         quo;
  logic                                hi_pass;

  logic [mcsp_pkg::DUTY_W-1:0]         duty_sat;
  logic [mcsp_pkg::DIVIDEND_W:0]       trial;
  logic                                ge;
  logic [mcsp_pkg::DIVIDEND_W-1:0]     rem_next;
  logic [mcsp_pkg::WAIT_W-1:0]         quo_next;

  // Saturate duty to full scale
  assign duty_sat = (duty_pct > mcsp_pkg::DUTY_FULL) ? mcsp_pkg::DUTY_FULL : duty_pct;

  // One restoring division step: bring down the next dividend bit
  assign trial    = {rem, num_sh[mcsp_pkg::DIVIDEND_W-1]};
  assign ge       = mcsp_pkg::DEN_W'(trial) >= den;
  assign rem_next = ge ? mcsp_pkg::DIVIDEND_W'(trial - den[mcsp_pkg::DIVIDEND_W:0])
                       : trial[mcsp_pkg::DIVIDEND_W-1:0];
  assign quo_next = {quo[mcsp_pkg::WAIT_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        W_IDLE: begin
          done <= 1'b0;
          if (start) begin
            mcand   <= mcsp_pkg::DEN_W'(freq_hz);
            mplier  <= timebase_ms;
            den     <= '0;
            duty_q  <= duty_sat;
            res.inf <= (freq_hz == '0) || (timebase_ms == '0);
            cnt     <= '0;
            state   <= W_MUL;
          end
        end
        // Shift-add multiply, one timebase bit per cycle
        W_MUL: begin
          den    <= den + (mplier[0] ? mcand : '0);
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == MUL_LAST) begin
            cnt     <= '0;
            num_sh  <= mcsp_pkg::dividend(duty_q);
            rem     <= '0;
            quo     <= '0;
            hi_pass <= 1'b0;
            state   <= W_DIV;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        // Low phase first, then high phase, one quotient bit per cycle
        W_DIV: begin
          if (cnt == DIV_LAST && !hi_pass) begin
            cnt     <= '0;
            res.lo  <= quo_next;
            hi_pass <= 1'b1;
            num_sh  <= mcsp_pkg::dividend(mcsp_pkg::DUTY_FULL - duty_q);
            rem     <= '0;
            quo     <= '0;
          end else begin
            num_sh <= num_sh << 1;
            rem    <= rem_next;
            quo    <= quo_next;
            if (cnt == DIV_LAST) begin
              cnt    <= '0;
              res.hi <= quo_next;
              done   <= 1'b1;
              state  <= W_IDLE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// ===== src/mcsp_chan_bank.sv =====
module mcsp_chan_bank (
  input  logic                                clk,
  input  logic                                rst,
  input  mcsp_pkg::bank_cmd_t                 cmd,
  output logic [mcsp_pkg::NUM_CHANNELS-1:0]   levels,
  output logic [mcsp_pkg::NUM_CHANNELS-1:0]   allocated,
  output logic [mcsp_pkg::CH_W-1:0]           grant,
  output logic                                grant_ok
);

  logic [mcsp_pkg::NUM_CHANNELS-1:0] running;
  logic [mcsp_pkg::ELAPSED_W-1:0]    elapsed [mcsp_pkg::NUM_CHANNELS];
  logic [mcsp_pkg::WAIT_W-1:0]       hi_wait [mcsp_pkg::NUM_CHANNELS];
  logic [mcsp_pkg::WAIT_W-1:0]       lo_wait [mcsp_pkg::NUM_CHANNELS];
  logic [mcsp_pkg::NUM_CHANNELS-1:0] wait_inf;

  logic [mcsp_pkg::ELAPSED_W-1:0]    e_inc;
  logic [mcsp_pkg::WAIT_W-1:0]       cur_wait;
  logic                              fire;

  // Find the lowest free channel
  always_comb begin
    grant    = '0;
    grant_ok = 1'b0;
    for (int c = mcsp_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
      if (!allocated[c]) begin
        grant    = mcsp_pkg::CH_W'(c);
        grant_ok = 1'b1;
      end
    end
  end

  // Tick check of the scanned channel; elapsed count saturates
  always_comb begin
    e_inc    = (&elapsed[cmd.scan]) ? elapsed[cmd.scan]
                                    : elapsed[cmd.scan] + mcsp_pkg::ELAPSED_W'(1);
    cur_wait = levels[cmd.scan] ? hi_wait[cmd.scan] : lo_wait[cmd.scan];
    fire     = running[cmd.scan] && !wait_inf[cmd.scan] &&
               (e_inc > mcsp_pkg::ELAPSED_W'(cur_wait));
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      allocated <= '0;
      running   <= '0;
      levels    <= '0;
    end else begin
      if (cmd.alloc && grant_ok) begin
        allocated[grant] <= 1'b1;
        running[grant]   <= 1'b0;
      end
      if (cmd.stop && allocated[cmd.ch]) begin
        running[cmd.ch] <= 1'b0;
        levels[cmd.ch]  <= cmd.lvl;
      end
      if (cmd.commit) begin
        running[cmd.ch] <= 1'b1;
        levels[cmd.ch]  <= cmd.lvl;
      end
      if (cmd.step && fire) begin
        levels[cmd.scan] <= ~levels[cmd.scan];
      end
    end
  end

  // Per-channel timing
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hi_wait[cmd.ch]  <= cmd.res.hi;
      lo_wait[cmd.ch]  <= cmd.res.lo;
      wait_inf[cmd.ch] <= cmd.res.inf;
      elapsed[cmd.ch]  <= '0;
    end
    if (cmd.step && running[cmd.scan]) begin
      elapsed[cmd.scan] <= fire ? '0 : e_inc;
    end
  end

endmodule

// ===== src/multi_channel_soft_pwm_unit.sv =====
// Eight-channel software PWM generator. Each input item is a tick, an allocate,
// a start or a stop, and each gives exactly one result: the pin levels of all
// channels, plus the granted channel for an allocate. A tick checks the channels
// one per cycle. A start on an allocated channel takes the divisor freq_hz *
// timebase_ms from a shift-add multiply and each phase wait from a 10-step
// restoring division, low phase then high phase. One item is worked on at a
// time; a new item is taken while the previous result still sits in the output
// register. timebase_ms is sampled when a start is taken.
module multi_channel_soft_pwm_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mcsp_pkg::TB_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [mcsp_pkg::CH_W-1:0]           channel,
  input  logic [mcsp_pkg::FREQ_W-1:0]         freq_hz,
  input  logic [mcsp_pkg::DUTY_W-1:0]         duty_pct,
  input  logic                                level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          pin_levels,
  output logic [2:0]                          alloc_channel,
  output logic                                alloc_ok
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CALC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  localparam logic [mcsp_pkg::CH_W-1:0] SCAN_LAST = mcsp_pkg::CH_W'(mcsp_pkg::NUM_CHANNELS - 1);

  state_t                             state;
  state_t                             state_next;
  logic [mcsp_pkg::TB_W-1:0]          timebase_ms;
  logic [mcsp_pkg::CH_W-1:0]          scan_idx;
  logic [mcsp_pkg::CH_W-1:0]          ch_q;
  logic                               lvl_q;
  logic [mcsp_pkg::CH_W-1:0]          grant_q;
  logic                               ok_q;

  logic                               in_acc;
  logic                               out_load;
  logic                               calc_start;
  logic                               calc_done;
  mcsp_pkg::wait_res_t                calc_res;
  mcsp_pkg::bank_cmd_t                cmd;
  logic [mcsp_pkg::NUM_CHANNELS-1:0]  levels;
  logic [mcsp_pkg::NUM_CHANNELS-1:0]  allocated;
  logic [mcsp_pkg::CH_W-1:0]          grant;
  logic                               grant_ok;
  mcsp_pkg::action_t                  act;

  assign act      = mcsp_pkg::action_t'(action);
  assign in_stall = rst || (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_RESULT) && (!out_valid || !out_stall);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timebase_ms <= mcsp_pkg::TB_W'(1);
    end else if (cfg_wr_en) begin
      timebase_ms <= cfg_wr_data;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    calc_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (act)
            mcsp_pkg::ACT_TICK: state_next = S_SCAN;
            mcsp_pkg::ACT_START: begin
              if (allocated[channel]) begin
                calc_start = 1'b1;
                state_next = S_CALC;
              end else begin
                state_next = S_RESULT;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_CALC:   if (calc_done) state_next = S_RESULT;
      S_SCAN:   if (scan_idx == SCAN_LAST) state_next = S_RESULT;
      S_RESULT: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_idx <= scan_idx + mcsp_pkg::CH_W'(1);
      end else begin
        scan_idx <= '0;
      end
    end
  end

  // Hold item fields and the allocate answer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_q    <= channel;
      lvl_q   <= level;
      grant_q <= (act == mcsp_pkg::ACT_ALLOC && grant_ok) ? grant : '0;
      ok_q    <= (act == mcsp_pkg::ACT_ALLOC) && grant_ok;
    end
  end

  // Bank commands
  always_comb begin
    cmd.alloc  = in_acc && (act == mcsp_pkg::ACT_ALLOC);
    cmd.stop   = in_acc && (act == mcsp_pkg::ACT_STOP);
    cmd.commit = (state == S_CALC) && calc_done;
    cmd.step   = (state == S_SCAN);
    cmd.ch     = (state == S_IDLE) ? channel : ch_q;
    cmd.lvl    = (state == S_IDLE) ? level : lvl_q;
    cmd.scan   = scan_idx;
    cmd.res    = calc_res;
  end

  mcsp_wait_calc u_wait_calc (
    .clk         (clk),
    .rst         (rst),
    .start       (calc_start),
    .freq_hz     (freq_hz),
    .timebase_ms (timebase_ms),
    .duty_pct    (duty_pct),
    .done        (calc_done),
    .res         (calc_res)
  );

  mcsp_chan_bank u_chan_bank (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .levels    (levels),
    .allocated (allocated),
    .grant     (grant),
    .grant_ok  (grant_ok)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pin_levels    <= 8'(levels);
      alloc_channel <= 3'(grant_q);
      alloc_ok      <= ok_q;
    end
  end

  a_alloc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alloc_ok || alloc_channel == 3'd0))
    else $error("alloc_channel nonzero without a grant");

  a_wait_range: assert property (@(posedge clk) disable iff (rst)
    (calc_done && !calc_res.inf) |->
      (calc_res.hi <= mcsp_pkg::WAIT_LIMIT && calc_res.lo <= mcsp_pkg::WAIT_LIMIT))
    else $error("phase wait out of range");

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> (state == S_CALC))
    else $error("wait result arrived outside a start");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_idx == SCAN_LAST) |=> (state == S_RESULT))
    else $error("tick scan did not finish");

endmodule

// ===== verif/tb_multi_channel_soft_pwm_unit.sv =====
`timescale 1ns / 100ps

module tb_multi_channel_soft_pwm_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [7:0] pins;
    logic [2:0] grant;
    logic       ok;
  } pwm_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [mcsp_pkg::TB_W-1:0]    cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   action = '0;
  logic [mcsp_pkg::CH_W-1:0]    channel = '0;
  logic [mcsp_pkg::FREQ_W-1:0]  freq_hz = '0;
  logic [mcsp_pkg::DUTY_W-1:0]  duty_pct = '0;
  logic                         level = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [7:0]                   pin_levels;
  logic [2:0]                   alloc_channel;
  logic                         alloc_ok;

  // Predicted channel state
  logic [31:0]                  pwm_ticks;
  logic [7:0]                   chan_alloc;
  logic [7:0]                   chan_run;
  logic [7:0]                   chan_lvl;
  logic [31:0]                  toggle_tick [mcsp_pkg::NUM_CHANNELS];
  logic [31:0]                  hi_wait [mcsp_pkg::NUM_CHANNELS];
  logic [31:0]                  lo_wait [mcsp_pkg::NUM_CHANNELS];
  logic [mcsp_pkg::TB_W-1:0]    timebase;

  pwm_result_t                  levels_due[$];
  int                           err_count = 0;
  int                           quiet_cycles = 0;
  int                           tx_idle_pct = 0;
  int                           rx_idle_pct = 0;
  bit                           hold_off_req = 1'b0;
  int                           hold_off_left = 0;

  multi_channel_soft_pwm_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .channel       (channel),
    .freq_hz       (freq_hz),
    .duty_pct      (duty_pct),
    .level         (level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pin_levels    (pin_levels),
    .alloc_channel (alloc_channel),
    .alloc_ok      (alloc_ok)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ticks per phase: floor(10 * share / (freq * timebase)), or never when either is zero
  function automatic logic [31:0] phase_ticks(input logic [mcsp_pkg::DUTY_W-1:0] share,
                                              input logic [mcsp_pkg::FREQ_W-1:0] freq,
                                              input logic [mcsp_pkg::TB_W-1:0] tb);
    logic [31:0] den;
    if (freq == '0 || tb == '0) return 32'hFFFF_FFFF;
    den = {16'd0, freq} * {22'd0, tb};
    return (32'd10 * {25'd0, share}) / den;
  endfunction

  // Apply one transfer to the predicted state and return the pin levels it yields
  function automatic pwm_result_t next_pin_state(input mcsp_pkg::action_t act,
                                                 input logic [mcsp_pkg::CH_W-1:0] ch,
                                                 input logic [mcsp_pkg::FREQ_W-1:0] freq,
                                                 input logic [mcsp_pkg::DUTY_W-1:0] duty,
                                                 input logic lvl);
    pwm_result_t r;
    logic [mcsp_pkg::DUTY_W-1:0] d;
    logic [31:0] phase_len;
    bit granted;
    r = '0;
    granted = 1'b0;
    d = (duty > mcsp_pkg::DUTY_FULL) ? mcsp_pkg::DUTY_FULL : duty;
    case (act)
      mcsp_pkg::ACT_TICK: begin
        pwm_ticks = pwm_ticks + 32'd1;
        for (int c = 0; c < mcsp_pkg::NUM_CHANNELS; c++) begin
          if (chan_alloc[c] && chan_run[c]) begin
            phase_len = chan_lvl[c] ? hi_wait[c] : lo_wait[c];
            if (pwm_ticks - toggle_tick[c] > phase_len) begin
              chan_lvl[c] = ~chan_lvl[c];
              toggle_tick[c] = pwm_ticks;
            end
          end
        end
      end
      mcsp_pkg::ACT_ALLOC: begin
        for (int c = 0; c < mcsp_pkg::NUM_CHANNELS; c++) begin
          if (!granted && !chan_alloc[c]) begin
            chan_alloc[c] = 1'b1;
            chan_run[c] = 1'b0;
            r.grant = c[2:0];
            r.ok = 1'b1;
            granted = 1'b1;
          end
        end
      end
      mcsp_pkg::ACT_START: begin
        if (chan_alloc[ch]) begin
          hi_wait[ch] = phase_ticks(mcsp_pkg::DUTY_FULL - d, freq, timebase);
          lo_wait[ch] = phase_ticks(d, freq, timebase);
          toggle_tick[ch] = pwm_ticks;
          chan_run[ch] = 1'b1;
          chan_lvl[ch] = lvl;
        end
      end
      default: begin
        if (chan_alloc[ch]) begin
          chan_run[ch] = 1'b0;
          chan_lvl[ch] = lvl;
        end
      end
    endcase
    r.pins = chan_lvl;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one item, hold it until the transfer, then predict its result
  task automatic send_pwm_item(input mcsp_pkg::action_t act,
                               input logic [mcsp_pkg::CH_W-1:0] ch,
                               input logic [mcsp_pkg::FREQ_W-1:0] freq,
                               input logic [mcsp_pkg::DUTY_W-1:0] duty,
                               input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    freq_hz  <= freq;
    duty_pct <= duty;
    level    <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    levels_due.push_back(next_pin_state(act, ch, freq, duty, lvl));
  endtask

  // Drop valid and wait until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_timebase(input logic [mcsp_pkg::TB_W-1:0] tb);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    timebase = tb;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_pwm_item(mcsp_pkg::ACT_TICK, 3'($urandom), 16'($urandom),
                             7'($urandom), 1'($urandom));
  endtask

  // Start and stop on channels nobody has claimed must leave them alone
  task automatic test_unallocated_ignored();
    send_pwm_item(mcsp_pkg::ACT_STOP, 3'd3, 16'd100, 7'd50, 1'b1);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd5, 16'd1, 7'd50, 1'b1);
  endtask

  // Claim channels, start them across the corner settings, then exhaust the pool
  task automatic test_alloc_and_start();
    repeat (7) send_pwm_item(mcsp_pkg::ACT_ALLOC, 3'd7, 16'hFFFF, 7'h7F, 1'b1);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd0, 16'd0, 7'd50, 1'b1);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd1, 16'hFFFF, 7'h7F, 1'b0);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd2, 16'd1, 7'd0, 1'b1);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd3, 16'd10, 7'd100, 1'b0);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd7, 16'd2, 7'd50, 1'b1);
    send_ticks(3);
    send_pwm_item(mcsp_pkg::ACT_STOP, 3'd1, 16'd0, 7'd0, 1'b1);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd2, 16'd200, 7'd64, 1'b0);
    send_pwm_item(mcsp_pkg::ACT_ALLOC, 3'd0, 16'd0, 7'd0, 1'b0);
    send_pwm_item(mcsp_pkg::ACT_ALLOC, 3'd0, 16'd0, 7'd0, 1'b0);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd7, 16'd3, 7'd33, 1'b1);
    send_ticks(3);
  endtask

  // Zero, widest and top-of-range tick periods
  task automatic test_timebase_extremes();
    write_timebase(10'd0);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd4, 16'd500, 7'd50, 1'b1);
    send_ticks(2);
    write_timebase(10'd1023);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd5, 16'hFFFF, 7'd100, 1'b0);
    send_ticks(2);
    write_timebase(10'd1000);
    send_pwm_item(mcsp_pkg::ACT_START, 3'd6, 16'd1, 7'd50, 1'b0);
    send_ticks(2);
  endtask

  // Mostly ticks between starts and stops, so channels run through many phases
  task automatic test_random_traffic(input int n, input logic [mcsp_pkg::TB_W-1:0] tb,
                                     input int tx_pct, input int rx_pct);
    int pick;
    logic [mcsp_pkg::FREQ_W-1:0] freq;
    logic [mcsp_pkg::DUTY_W-1:0] duty;
    write_timebase(tb);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2, 3: freq = 16'($urandom_range(1, 20));
        4, 5, 6:    freq = 16'($urandom_range(20, 1000));
        7:          freq = 16'd0;
        8:          freq = 16'hFFFF;
        default:    freq = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0:       duty = 7'd0;
        1:       duty = 7'd100;
        default: duty = 7'($urandom);
      endcase
      if (pick < 68)
        send_pwm_item(mcsp_pkg::ACT_TICK, 3'($urandom), freq, duty, 1'($urandom));
      else if (pick < 71)
        send_pwm_item(mcsp_pkg::ACT_ALLOC, 3'($urandom), freq, duty, 1'($urandom));
      else if (pick < 88)
        send_pwm_item(mcsp_pkg::ACT_START, 3'($urandom), freq, duty, 1'($urandom));
      else
        send_pwm_item(mcsp_pkg::ACT_STOP, 3'($urandom), freq, duty, 1'($urandom));
    end
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_output_hold_off();
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_req = 1'b1;
    send_pwm_item(mcsp_pkg::ACT_START, 3'd0, 16'd5, 7'd30, 1'b1);
    send_ticks(30);
    send_pwm_item(mcsp_pkg::ACT_STOP, 3'd0, 16'd0, 7'd0, 1'b0);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin : check_out
    pwm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        report_mismatch("unexpected result, pin_levels", pin_levels, 0);
      end else begin
        want = levels_due.pop_front();
        if (pin_levels !== want.pins) report_mismatch("pin_levels", pin_levels, want.pins);
        if (alloc_channel !== want.grant)
          report_mismatch("alloc_channel", alloc_channel, want.grant);
        if (alloc_ok !== want.ok) report_mismatch("alloc_ok", alloc_ok, want.ok);
      end
    end
  end

  // Abort when nothing moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[multi_channel_soft_pwm_unit] ERROR");
      $finish;
    end
  end

  initial begin
    pwm_ticks  = '0;
    chan_alloc = '0;
    chan_run   = '0;
    chan_lvl   = '0;
    timebase   = 10'd1;
    for (int c = 0; c < mcsp_pkg::NUM_CHANNELS; c++) begin
      toggle_tick[c] = '0;
      hi_wait[c]     = '0;
      lo_wait[c]     = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 22;
    rx_idle_pct = 53;
    test_unallocated_ignored();
    test_alloc_and_start();
    test_timebase_extremes();
    test_random_traffic(700, 10'd1, 22, 53);
    test_output_hold_off();
    test_random_traffic(700, 10'($urandom_range(1, 30)), 53, 22);
    test_random_traffic(600, 10'd2, 0, 0);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (levels_due.size() != 0) begin
      report_mismatch("missing result, pin_levels", 0, levels_due[0].pins);
      void'(levels_due.pop_front());
    end
    if (err_count == 0)
      $display("[multi_channel_soft_pwm_unit] OK");
    else
      $display("[multi_channel_soft_pwm_unit] ERROR");
    $finish;
  end

endmodule
